// File: rtl/aspw_pkg.sv
// ----------------------------------------------------------------------------
// aspw_pkg: shared types and constants
// Item layouts, configuration set, and the command/status bundle that joins
// the controller and the datapath of the plot window.
// ----------------------------------------------------------------------------
package aspw_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int HEIGHT_W   = 6;
    localparam int SLOT_W     = 6;
    localparam int SUM_W      = 14;
    localparam int DIVISOR_W  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [HEIGHT_W-1:0] PLOT_HEIGHT_RST = 6'd63;
    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST   = 8'd0;
    localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST  = 8'd255;
    localparam logic                AUTO_EXPAND_RST = 1'b1;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_PLOT_HEIGHT = 2'd0,
        REG_RANGE_LOW   = 2'd1,
        REG_RANGE_HIGH  = 2'd2,
        REG_AUTO_EXPAND = 2'd3
    } reg_index_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] flow_sample;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [HEIGHT_W-1:0] point_height;
        logic [SAMPLE_W-1:0] sample_value;
        logic [SAMPLE_W-1:0] mean_flow;
        logic [SAMPLE_W-1:0] current_low;
        logic [SAMPLE_W-1:0] current_high;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] plot_height;
        logic [SAMPLE_W-1:0] range_low;
        logic [SAMPLE_W-1:0] range_high;
        logic                auto_expand;
    } cfg_t;

    typedef enum logic {
        RD_SLOT = 1'b0,
        RD_HEAD = 1'b1
    } rd_sel_t;

    typedef enum logic {
        DIV_ROW  = 1'b0,
        DIV_MEAN = 1'b1
    } div_sel_t;

    typedef enum logic {
        ROW_MEM = 1'b0,
        ROW_NEW = 1'b1
    } row_src_t;

    typedef struct packed {
        logic     load_push;
        logic     load_clear;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     row_prep;
        row_src_t row_src;
        logic     div_start;
        div_sel_t div_sel;
        logic     height_wr;
        logic     drop;
        logic     insert;
        logic     mean_ld;
        logic     slot_clr;
        logic     slot_inc;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic recalc;
        logic full;
        logic slot_last;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/aspw_stream_if.sv
// ----------------------------------------------------------------------------
// aspw_stream_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface aspw_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: rtl/aspw_div.sv
// ----------------------------------------------------------------------------
// aspw_div: serial restoring divider
// One quotient bit per cycle while busy; the quotient is complete once busy falls.
// ----------------------------------------------------------------------------
module aspw_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [aspw_pkg::SUM_W-1:0]     dividend,
    input  logic [aspw_pkg::DIVISOR_W-1:0] divisor,
    output logic                           busy,
    output logic [aspw_pkg::SUM_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(aspw_pkg::SUM_W);

    logic [aspw_pkg::DIVISOR_W-1:0] rem_reg;
    logic [aspw_pkg::DIVISOR_W-1:0] den_reg;
    logic [aspw_pkg::SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic [aspw_pkg::DIVISOR_W:0]   trial;
    logic [aspw_pkg::DIVISOR_W:0]   diff;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[aspw_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(aspw_pkg::SUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[aspw_pkg::DIVISOR_W-1:0] : trial[aspw_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[aspw_pkg::SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/aspw_datapath.sv
// ----------------------------------------------------------------------------
// aspw_datapath: window storage and arithmetic
// Ring buffer of samples and heights, range, running sum, mean, row scaling
// through the shared divider, and the result register.
// ----------------------------------------------------------------------------
module aspw_datapath #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aspw_pkg::cfg_t                cfg,
    input  logic [aspw_pkg::SAMPLE_W-1:0] flow_sample,
    input  aspw_pkg::dp_cmd_t             cmd,
    output aspw_pkg::dp_status_t          status,
    aspw_stream_if.source                 points
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = aspw_pkg::SAMPLE_W;
    localparam int HW    = aspw_pkg::HEIGHT_W;

    logic [SW-1:0] sample_mem [WINDOW_DEPTH];
    logic [HW-1:0] height_mem [WINDOW_DEPTH];

    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [aspw_pkg::SUM_W-1:0] sum_reg;
    logic [SW-1:0]              mean_reg;
    logic [SW-1:0]              low_reg;
    logic [SW-1:0]              high_reg;
    logic [SW-1:0]              new_reg;
    logic [SW-1:0]              smp_rd_reg;
    logic [HW-1:0]              hgt_rd_reg;
    logic [aspw_pkg::SUM_W-1:0] prod_reg;
    logic                       ge_high_reg;
    logic                       le_low_reg;
    logic                       out_valid_reg;
    aspw_pkg::out_item_t        out_item_reg;

    logic [IDX_W-1:0]               slot_addr;
    logic [IDX_W-1:0]               tail_addr;
    logic [IDX_W-1:0]               head_inc;
    logic [IDX_W-1:0]               rd_addr;
    logic [SW-1:0]                  row_x;
    logic [SW-1:0]                  row_diff;
    logic [aspw_pkg::SUM_W-1:0]     prod_next;
    logic [HW-1:0]                  row_value;
    logic                           div_go;
    logic [aspw_pkg::SUM_W-1:0]     div_dividend;
    logic [aspw_pkg::DIVISOR_W-1:0] div_divisor;
    logic                           div_busy;
    logic [aspw_pkg::SUM_W-1:0]     div_quotient;
    logic [SW-1:0]                  exp_low;
    logic [SW-1:0]                  exp_high;
    aspw_pkg::out_item_t            out_item_next;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] a);
        if (a >= (IDX_W+1)'(WINDOW_DEPTH))
        begin
            return IDX_W'(a - (IDX_W+1)'(WINDOW_DEPTH));
        end
        return IDX_W'(a);
    endfunction

    assign slot_addr = wrap_idx({1'b0, head_reg} + {1'b0, slot_reg});
    assign tail_addr = wrap_idx({1'b0, head_reg} + (IDX_W+1)'(fill_reg));
    assign head_inc  = wrap_idx({1'b0, head_reg} + (IDX_W+1)'(1));
    assign rd_addr   = (cmd.rd_sel == aspw_pkg::RD_HEAD) ? head_reg : slot_addr;

    assign row_x     = (cmd.row_src == aspw_pkg::ROW_NEW) ? new_reg : smp_rd_reg;
    assign row_diff  = high_reg - row_x;
    assign prod_next = aspw_pkg::SUM_W'(cfg.plot_height) * aspw_pkg::SUM_W'(row_diff);

    always_comb
    begin
        if (ge_high_reg)
        begin
            row_value = '0;
        end
        else if (le_low_reg)
        begin
            row_value = cfg.plot_height;
        end
        else
        begin
            row_value = div_quotient[HW-1:0];
        end
    end

    assign div_go = cmd.div_start &&
                    (cmd.div_sel == aspw_pkg::DIV_MEAN || (!ge_high_reg && !le_low_reg));
    assign div_dividend = (cmd.div_sel == aspw_pkg::DIV_MEAN) ? sum_reg : prod_reg;
    assign div_divisor  = (cmd.div_sel == aspw_pkg::DIV_MEAN) ?
                          aspw_pkg::DIVISOR_W'(fill_reg) : (high_reg - low_reg);

    aspw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign exp_low  = (cfg.auto_expand && flow_sample < low_reg) ? flow_sample : low_reg;
    assign exp_high = (cfg.auto_expand && flow_sample > high_reg) ? flow_sample : high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            mean_reg <= '0;
            low_reg  <= aspw_pkg::RANGE_LOW_RST;
            high_reg <= aspw_pkg::RANGE_HIGH_RST;
        end
        else
        begin
            if (cmd.load_clear)
            begin
                head_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
                mean_reg <= '0;
                low_reg  <= cfg.range_low;
                high_reg <= cfg.range_high;
            end
            if (cmd.load_push)
            begin
                low_reg  <= exp_low;
                high_reg <= exp_high;
            end
            if (cmd.drop)
            begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - 1'b1;
                sum_reg  <= sum_reg - aspw_pkg::SUM_W'(smp_rd_reg);
            end
            if (cmd.insert)
            begin
                fill_reg <= fill_reg + 1'b1;
                sum_reg  <= sum_reg + aspw_pkg::SUM_W'(new_reg);
            end
            if (cmd.mean_ld)
            begin
                mean_reg <= div_quotient[SW-1:0];
            end
            if (cmd.slot_clr)
            begin
                slot_reg <= '0;
            end
            else if (cmd.slot_inc)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_push)
        begin
            new_reg <= flow_sample;
        end
        if (cmd.rd_en)
        begin
            smp_rd_reg <= sample_mem[rd_addr];
            hgt_rd_reg <= height_mem[rd_addr];
        end
        if (cmd.row_prep)
        begin
            ge_high_reg <= row_x >= high_reg;
            le_low_reg  <= row_x <= low_reg;
            prod_reg    <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            sample_mem[tail_addr] <= new_reg;
            height_mem[tail_addr] <= row_value;
        end
        else if (cmd.height_wr)
        begin
            height_mem[slot_addr] <= row_value;
        end
    end

    always_comb
    begin
        out_item_next.slot_index   = aspw_pkg::SLOT_W'(slot_reg);
        out_item_next.point_height = hgt_rd_reg;
        out_item_next.sample_value = smp_rd_reg;
        out_item_next.mean_flow    = mean_reg;
        out_item_next.current_low  = low_reg;
        out_item_next.current_high = high_reg;
        out_item_next.last         = status.slot_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (points.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign points.valid   = out_valid_reg;
    assign points.payload = out_item_reg;

    assign status.recalc    = cfg.auto_expand && (fill_reg != '0);
    assign status.full      = fill_reg == CNT_W'(WINDOW_DEPTH);
    assign status.slot_last = (CNT_W'(slot_reg) + CNT_W'(1)) == fill_reg;
    assign status.div_busy  = div_busy;
    assign status.out_free  = !out_valid_reg || points.ready;

endmodule

// File: rtl/aspw_ctrl.sv
// ----------------------------------------------------------------------------
// aspw_ctrl: sequencing state machine
// Walks a push through rescale, drop, insert, mean and the result run; a clear is taken in idle.
// ----------------------------------------------------------------------------
module aspw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  aspw_pkg::op_t        in_op,
    output logic                 in_ready,
    input  aspw_pkg::dp_status_t status,
    output aspw_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RC_READ,
        S_RC_MUL,
        S_RC_DIV,
        S_RC_WAIT,
        S_PLACE,
        S_DROP,
        S_NEW_MUL,
        S_NEW_DIV,
        S_NEW_WAIT,
        S_MEAN_DIV,
        S_MEAN_WAIT,
        S_OUT_READ,
        S_OUT_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.slot_clr = 1'b1;
                    if (in_op == aspw_pkg::OP_CLEAR)
                    begin
                        cmd.load_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load_push = 1'b1;
                        state_next    = status.recalc ? S_RC_READ : S_PLACE;
                    end
                end
            end
            S_RC_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = aspw_pkg::RD_SLOT;
                state_next = S_RC_MUL;
            end
            S_RC_MUL:
            begin
                cmd.row_prep = 1'b1;
                cmd.row_src  = aspw_pkg::ROW_MEM;
                state_next   = S_RC_DIV;
            end
            S_RC_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = aspw_pkg::DIV_ROW;
                state_next    = S_RC_WAIT;
            end
            S_RC_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.height_wr = 1'b1;
                    if (status.slot_last)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.slot_inc = 1'b1;
                        state_next   = S_RC_READ;
                    end
                end
            end
            S_PLACE:
            begin
                if (status.full)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aspw_pkg::RD_HEAD;
                    state_next = S_DROP;
                end
                else
                begin
                    state_next = S_NEW_MUL;
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_NEW_MUL;
            end
            S_NEW_MUL:
            begin
                cmd.row_prep = 1'b1;
                cmd.row_src  = aspw_pkg::ROW_NEW;
                state_next   = S_NEW_DIV;
            end
            S_NEW_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = aspw_pkg::DIV_ROW;
                state_next    = S_NEW_WAIT;
            end
            S_NEW_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = aspw_pkg::DIV_MEAN;
                state_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.mean_ld  = 1'b1;
                    cmd.slot_clr = 1'b1;
                    state_next   = S_OUT_READ;
                end
            end
            S_OUT_READ:
            begin
                if (status.out_free)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aspw_pkg::RD_SLOT;
                    state_next = S_OUT_LOAD;
                end
            end
            S_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                if (status.slot_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_OUT_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/autoscaled_scrolling_plot_window_top.sv
// ----------------------------------------------------------------------------
// autoscaled_scrolling_plot_window_top: autoscaled scrolling plot window
// Sliding window of flow samples with running mean and per-sample plot rows,
// rescaled on pushes while auto_expand is set, streamed out as one run per push.
// ----------------------------------------------------------------------------
//  channel   role    payload                                    transaction
//  samples   sink    op, flow_sample                            valid & ready
//  points    source  slot_index .. current_high, last           valid & ready
//  apb       slave   plot_height, range_low/high, auto_expand   psel&penable&pwrite
//
//  A push walks through rescale (auto_expand only), drop (full window only),
//  insert, mean and a run of M results, M the run length; each quotient
//  comes from the shared serial divider. A clear empties the window.
//  samples.ready is high only between transactions; a stalled points channel
//  holds the run one result at a time. The controller is idle after reset.
// ----------------------------------------------------------------------------
module autoscaled_scrolling_plot_window_top #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    aspw_stream_if.sink                     samples,
    aspw_stream_if.source                   points,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aspw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aspw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aspw_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    aspw_pkg::cfg_t       cfg_reg;
    aspw_pkg::reg_index_t reg_sel;
    aspw_pkg::dp_cmd_t    cmd;
    aspw_pkg::dp_status_t status;

    assign reg_sel = aspw_pkg::reg_index_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plot_height <= aspw_pkg::PLOT_HEIGHT_RST;
            cfg_reg.range_low   <= aspw_pkg::RANGE_LOW_RST;
            cfg_reg.range_high  <= aspw_pkg::RANGE_HIGH_RST;
            cfg_reg.auto_expand <= aspw_pkg::AUTO_EXPAND_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                aspw_pkg::REG_PLOT_HEIGHT: cfg_reg.plot_height <= pwdata[aspw_pkg::HEIGHT_W-1:0];
                aspw_pkg::REG_RANGE_LOW:   cfg_reg.range_low   <= pwdata[aspw_pkg::SAMPLE_W-1:0];
                aspw_pkg::REG_RANGE_HIGH:  cfg_reg.range_high  <= pwdata[aspw_pkg::SAMPLE_W-1:0];
                aspw_pkg::REG_AUTO_EXPAND: cfg_reg.auto_expand <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            aspw_pkg::REG_PLOT_HEIGHT: prdata = aspw_pkg::APB_DATA_W'(cfg_reg.plot_height);
            aspw_pkg::REG_RANGE_LOW:   prdata = aspw_pkg::APB_DATA_W'(cfg_reg.range_low);
            aspw_pkg::REG_RANGE_HIGH:  prdata = aspw_pkg::APB_DATA_W'(cfg_reg.range_high);
            aspw_pkg::REG_AUTO_EXPAND: prdata = aspw_pkg::APB_DATA_W'(cfg_reg.auto_expand);
        endcase
    end

    aspw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_op    (samples.payload.op),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    aspw_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .flow_sample (samples.payload.flow_sample),
        .cmd         (cmd),
        .status      (status),
        .points      (points)
    );

endmodule

// File: rtl/aspw_checker.sv
// ----------------------------------------------------------------------------
// aspw_checker: port-level checks of the plot window
// Result runs count up from slot zero and keep one mean and range per run.
// ----------------------------------------------------------------------------
module aspw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input aspw_pkg::out_item_t out_item
);

    logic [aspw_pkg::SLOT_W-1:0]   exp_slot_reg;
    logic                          run_open_reg;
    logic [aspw_pkg::SAMPLE_W-1:0] run_mean_reg;
    logic [aspw_pkg::SAMPLE_W-1:0] run_low_reg;
    logic [aspw_pkg::SAMPLE_W-1:0] run_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_slot_reg <= '0;
            run_open_reg <= 1'b0;
            run_mean_reg <= '0;
            run_low_reg  <= '0;
            run_high_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_slot_reg <= out_item.last ? '0 : out_item.slot_index + 1'b1;
            run_open_reg <= !out_item.last;
            run_mean_reg <= out_item.mean_flow;
            run_low_reg  <= out_item.current_low;
            run_high_reg <= out_item.current_high;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.slot_index == exp_slot_reg)
        else $error("result slot out of order");

    a_run_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_open_reg |->
            out_item.mean_flow == run_mean_reg &&
            out_item.current_low == run_low_reg &&
            out_item.current_high == run_high_reg)
        else $error("mean or range changed within a run");

endmodule

bind autoscaled_scrolling_plot_window_top aspw_checker u_aspw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .out_item  (points.payload)
);
